### sv/tefr_pkg.sv
// shared types and constants of the half-space triangle rasterizer
`timescale 1ns / 1ps

package tefr_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 14;

  // fixed field widths
  localparam int CANVAS_BITS    = 13;
  localparam int COLOR_BITS     = 32;
  localparam int STATUS_BITS    = 3;
  localparam int CFG_INDEX_BITS = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FILL_BIAS     = 2'd2;

  // configuration reset values
  localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RST  = 13'd640;
  localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RST = 13'd480;

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_ACCEPT = 3'd0,
    ST_REJECT = 3'd1,
    ST_WRITE  = 3'd2,
    ST_SKIP   = 3'd3,
    ST_IDLE   = 3'd4
  } status_t;

  // control record passed from the sequencer to the edge evaluator
  typedef struct packed {
    logic    is_step;
    status_t status;
    logic    last;
    logic    on_canvas;
  } ctl_t;

endpackage

### sv/tefr_seq.sv
// input register, triangle setup and bounding box scan sequencer
`timescale 1ns / 1ps

module tefr_seq import tefr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CANVAS_BITS-1:0]        cfg_wdata,
  // request side
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic signed [COORD_BITS-1:0]  in_vtx [6],
  input  logic [COLOR_BITS-1:0]         in_color,
  // toward the edge evaluator
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output ctl_t                          dn_ctl,
  output logic signed [COORD_BITS-1:0]  dn_px,
  output logic signed [COORD_BITS-1:0]  dn_py,
  output logic signed [COORD_BITS:0]    dn_dx [3],
  output logic signed [COORD_BITS:0]    dn_dy [3],
  output logic signed [COORD_BITS:0]    dn_ex [3],
  output logic signed [COORD_BITS:0]    dn_ey [3],
  output logic [2:0]                    dn_bias,
  output logic [COLOR_BITS-1:0]         dn_color
);

  localparam int C    = COORD_BITS;
  localparam int DW   = COORD_BITS + 1;
  localparam int CMPW = ((COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS) + 2;

  typedef logic signed [C-1:0]    crd_t;
  typedef logic signed [DW-1:0]   dlt_t;
  typedef logic signed [CMPW-1:0] cmp_t;

  // configuration registers
  logic [CANVAS_BITS-1:0] width_r, height_r;
  logic                   fr_bias_r;

  // input register
  logic                   s1_valid_r;
  logic                   s1_req_r;
  crd_t                   s1_vtx_r [6];
  logic [COLOR_BITS-1:0]  s1_color_r;

  // triangle and scan state
  crd_t vx_r [3], vx_nxt [3];
  crd_t vy_r [3], vy_nxt [3];
  dlt_t ex_r [3], ex_nxt [3];
  dlt_t ey_r [3], ey_nxt [3];
  logic [2:0] bias_r, bias_nxt;
  logic [COLOR_BITS-1:0] color_r, color_nxt;
  crd_t ymin_r, ymin_nxt, xmax_r, xmax_nxt, ymax_r, ymax_nxt;
  crd_t sx_r, sx_nxt, sy_r, sy_nxt;
  logic active_r, active_nxt;

  // stage toward the evaluator
  logic                   s2_valid_r;
  ctl_t                   s2_ctl_r, s2_ctl_nxt;
  crd_t                   s2_px_r, s2_px_nxt, s2_py_r, s2_py_nxt;
  dlt_t                   s2_dx_r [3], s2_dx_nxt [3];
  dlt_t                   s2_dy_r [3], s2_dy_nxt [3];

  logic s2_free, s1_fire;

  // load setup values
  crd_t lx [3], ly [3];
  crd_t xmin, xmax, ymin, ymax;
  logic ld_reject;
  logic [2:0] ld_tl;
  dlt_t lex [3], ley [3];

  // step values
  dlt_t ny;
  logic st_last, st_on_canvas;

  function automatic cmp_t cext(input crd_t v);
    return CMPW'(v);
  endfunction

  function automatic cmp_t uext(input logic [CANVAS_BITS-1:0] v);
    return $signed({{(CMPW-CANVAS_BITS){1'b0}}, v});
  endfunction

  // handshake
  assign s2_free  = !s2_valid_r || dn_ready;
  assign s1_fire  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  // bounding box, reject test and edge setup of a load
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lx[i] = s1_vtx_r[2*i];
      ly[i] = s1_vtx_r[2*i+1];
    end
    xmin = (lx[0] < lx[1]) ? lx[0] : lx[1];
    xmin = (xmin < lx[2]) ? xmin : lx[2];
    xmax = (lx[0] > lx[1]) ? lx[0] : lx[1];
    xmax = (xmax > lx[2]) ? xmax : lx[2];
    ymin = (ly[0] < ly[1]) ? ly[0] : ly[1];
    ymin = (ymin < ly[2]) ? ymin : ly[2];
    ymax = (ly[0] > ly[1]) ? ly[0] : ly[1];
    ymax = (ymax > ly[2]) ? ymax : ly[2];
    ld_reject = xmax[C-1] || (cext(xmin) >= uext(width_r)) ||
                ymax[C-1] || (cext(ymin) >= uext(height_r)) ||
                (xmin == xmax) || (ymin == ymax);
    for (int i = 0; i < 3; i++) begin
      int b;
      b = (i == 2) ? 0 : i + 1;
      lex[i] = DW'(lx[b]) - DW'(lx[i]);
      ley[i] = DW'(ly[b]) - DW'(ly[i]);
      ld_tl[i] = !(((ly[i] == ly[b]) && (lx[i] < lx[b])) || (ly[i] < ly[b]));
    end
  end

  // scan position tests of a step
  always_comb begin
    ny           = DW'(sy_r) + DW'(1);
    st_last      = ((DW'(sx_r) + DW'(1)) == DW'(xmax_r)) && (ny == DW'(ymax_r));
    st_on_canvas = !sx_r[C-1] && (cext(sx_r) < uext(width_r)) &&
                   !sy_r[C-1] && (cext(sy_r) < uext(height_r));
  end

  // next state and stage contents
  always_comb begin
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    ex_nxt     = ex_r;
    ey_nxt     = ey_r;
    bias_nxt   = bias_r;
    color_nxt  = color_r;
    ymin_nxt   = ymin_r;
    xmax_nxt   = xmax_r;
    ymax_nxt   = ymax_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    active_nxt = active_r;
    s2_ctl_nxt = '{is_step: 1'b0, status: ST_IDLE, last: 1'b0, on_canvas: 1'b0};
    s2_px_nxt  = '0;
    s2_py_nxt  = '0;
    for (int i = 0; i < 3; i++) begin
      s2_dx_nxt[i] = DW'(sx_r) - DW'(vx_r[i]);
      s2_dy_nxt[i] = DW'(sy_r) - DW'(vy_r[i]);
    end
    if (s1_req_r == REQ_LOAD) begin
      vx_nxt    = lx;
      vy_nxt    = ly;
      color_nxt = s1_color_r;
      if (ld_reject) begin
        active_nxt        = 1'b0;
        s2_ctl_nxt.status = ST_REJECT;
        s2_ctl_nxt.last   = 1'b1;
      end else begin
        ex_nxt            = lex;
        ey_nxt            = ley;
        bias_nxt          = fr_bias_r ? ld_tl : 3'b000;
        ymin_nxt          = ymin;
        xmax_nxt          = xmax;
        ymax_nxt          = ymax;
        sx_nxt            = xmin;
        sy_nxt            = ymin;
        active_nxt        = 1'b1;
        s2_ctl_nxt.status = ST_ACCEPT;
      end
    end else if (active_r) begin
      s2_ctl_nxt.is_step   = 1'b1;
      s2_ctl_nxt.status    = ST_SKIP;
      s2_ctl_nxt.last      = st_last;
      s2_ctl_nxt.on_canvas = st_on_canvas;
      s2_px_nxt            = sx_r;
      s2_py_nxt            = sy_r;
      if (st_last) begin
        active_nxt = 1'b0;
      end else if (ny >= DW'(ymax_r)) begin
        sy_nxt = ymin_r;
        sx_nxt = C'(DW'(sx_r) + DW'(1));
      end else begin
        sy_nxt = C'(ny);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= CANVAS_WIDTH_RST;
      height_r  <= CANVAS_HEIGHT_RST;
      fr_bias_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  width_r   <= cfg_wdata;
        REG_CANVAS_HEIGHT: height_r  <= cfg_wdata;
        REG_FILL_BIAS:     fr_bias_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_req_r   <= in_req_type;
      s1_vtx_r   <= in_vtx;
      s1_color_r <= in_color;
    end
  end

  // triangle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (s1_fire) begin
      active_r <= active_nxt;
    end
    if (s1_fire) begin
      vx_r    <= vx_nxt;
      vy_r    <= vy_nxt;
      ex_r    <= ex_nxt;
      ey_r    <= ey_nxt;
      bias_r  <= bias_nxt;
      color_r <= color_nxt;
      ymin_r  <= ymin_nxt;
      xmax_r  <= xmax_nxt;
      ymax_r  <= ymax_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
    end
  end

  // stage register toward the evaluator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_fire;
    end
    if (s1_fire) begin
      s2_ctl_r <= s2_ctl_nxt;
      s2_px_r  <= s2_px_nxt;
      s2_py_r  <= s2_py_nxt;
      s2_dx_r  <= s2_dx_nxt;
      s2_dy_r  <= s2_dy_nxt;
    end
  end

  // edge setup and color are read from the latched triangle
  assign dn_valid = s2_valid_r;
  assign dn_ctl   = s2_ctl_r;
  assign dn_px    = s2_px_r;
  assign dn_py    = s2_py_r;
  assign dn_dx    = s2_dx_r;
  assign dn_dy    = s2_dy_r;
  assign dn_ex    = ex_r;
  assign dn_ey    = ey_r;
  assign dn_bias  = bias_r;
  assign dn_color = color_r;

endmodule

### sv/tefr_edge_eval.sv
// edge function multiply stage, coverage test and result register
`timescale 1ns / 1ps

module tefr_edge_eval import tefr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // from the sequencer
  input  logic                          up_valid,
  output logic                          up_ready,
  input  ctl_t                          up_ctl,
  input  logic signed [COORD_BITS-1:0]  up_px,
  input  logic signed [COORD_BITS-1:0]  up_py,
  input  logic signed [COORD_BITS:0]    up_dx [3],
  input  logic signed [COORD_BITS:0]    up_dy [3],
  input  logic signed [COORD_BITS:0]    up_ex [3],
  input  logic signed [COORD_BITS:0]    up_ey [3],
  input  logic [2:0]                    up_bias,
  input  logic [COLOR_BITS-1:0]         up_color,
  // result register
  output logic                          out_valid,
  input  logic                          out_ready,
  output status_t                       out_status,
  output logic signed [COORD_BITS-1:0]  out_px,
  output logic signed [COORD_BITS-1:0]  out_py,
  output logic [COLOR_BITS-1:0]         out_color,
  output logic                          out_last
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 2;

  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [EW-1:0] efn_t;

  logic                           s3_valid_r;
  ctl_t                           s3_ctl_r;
  logic signed [COORD_BITS-1:0]   s3_px_r, s3_py_r;
  prod_t                          s3_p0_r [3], s3_p1_r [3];
  logic [2:0]                     s3_bias_r;
  logic [COLOR_BITS-1:0]          s3_color_r;

  logic                           out_valid_r;
  status_t                        out_status_r, out_status_nxt;
  logic signed [COORD_BITS-1:0]   out_px_r, out_py_r;
  logic [COLOR_BITS-1:0]          out_color_r, out_color_nxt;
  logic                           out_last_r;

  logic out_free, s3_free, s3_fire;
  efn_t efn [3];
  logic covered;

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign s3_free  = !s3_valid_r || out_free;
  assign s3_fire  = s3_valid_r && out_free;
  assign up_ready = s3_free;

  // six independent products, one per edge term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_free) begin
      s3_valid_r <= up_valid;
    end
    if (s3_free && up_valid) begin
      s3_ctl_r   <= up_ctl;
      s3_px_r    <= up_px;
      s3_py_r    <= up_py;
      s3_bias_r  <= up_bias;
      s3_color_r <= up_color;
      for (int i = 0; i < 3; i++) begin
        s3_p0_r[i] <= PW'(up_ex[i]) * PW'(up_dy[i]);
        s3_p1_r[i] <= PW'(up_ey[i]) * PW'(up_dx[i]);
      end
    end
  end

  // edge functions plus bias, covered when all are at most zero
  always_comb begin
    covered = 1'b1;
    for (int i = 0; i < 3; i++) begin
      efn[i] = EW'(s3_p0_r[i]) - EW'(s3_p1_r[i]) + $signed({{(EW-1){1'b0}}, s3_bias_r[i]});
      if (!(efn[i][EW-1] || (efn[i] == '0))) begin
        covered = 1'b0;
      end
    end
    out_status_nxt = s3_ctl_r.status;
    out_color_nxt  = '0;
    if (s3_ctl_r.is_step) begin
      if (covered && s3_ctl_r.on_canvas) begin
        out_status_nxt = ST_WRITE;
        out_color_nxt  = s3_color_r;
      end else begin
        out_status_nxt = ST_SKIP;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s3_valid_r;
    end
    if (s3_fire) begin
      out_status_r <= out_status_nxt;
      out_px_r     <= s3_px_r;
      out_py_r     <= s3_py_r;
      out_color_r  <= out_color_nxt;
      out_last_r   <= s3_ctl_r.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_px     = out_px_r;
  assign out_py     = out_py_r;
  assign out_color  = out_color_r;
  assign out_last   = out_last_r;

endmodule

### sv/triangle_edge_function_rasterizer.sv
// top level of the half-space triangle rasterizer
//
//   channel   dir  handshake             contents
//   in_*      in   in_tvalid/in_tready   tuser request kind, tdata vertices and color
//   out_*     out  out_tvalid/out_tready tuser status, tdata pixel and color, tlast
//   cfg_*     in   cfg_we                canvas width, canvas height, fill bias
//
// one item is accepted per cycle unless out_tready stalls; after its input transfer
// it passes the input register, sequencer stage, multiply stage and result register
// the scan sequencer holds all triangle state, so steps right after a load see it
// a stall on out_tready fills bubbles first, then backs up to in_tready
// reset (rst_n low, synchronous) empties the pipeline, drops any triangle and
// loads the configuration defaults
`timescale 1ns / 1ps

module triangle_edge_function_rasterizer import tefr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // configuration write port
  input  logic                                          cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]                     cfg_index,
  input  logic [CANVAS_BITS-1:0]                        cfg_wdata,
  // request stream
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // v1_x, v1_y, v2_x, v2_y, v3_x, v3_y, tri_color
  input  logic [((6*COORD_BITS+COLOR_BITS+7)/8)*8-1:0]  in_tdata,
  // req_type
  input  logic                                          in_tuser,
  // result stream
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0]  out_tdata,
  // status
  output logic [STATUS_BITS-1:0]                        out_tuser,
  // last_pixel
  output logic                                          out_tlast
);

  localparam int C      = COORD_BITS;
  localparam int OUT_DW = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

  logic signed [C-1:0]  in_vtx [6];
  logic [COLOR_BITS-1:0] in_color;

  logic                 dn_valid, dn_ready;
  ctl_t                 dn_ctl;
  logic signed [C-1:0]  dn_px, dn_py;
  logic signed [C:0]    dn_dx [3], dn_dy [3], dn_ex [3], dn_ey [3];
  logic [2:0]           dn_bias;
  logic [COLOR_BITS-1:0] dn_color;

  status_t              res_status;
  logic signed [C-1:0]  res_px, res_py;
  logic [COLOR_BITS-1:0] res_color;

  // unpack the request payload
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      in_vtx[k] = $signed(in_tdata[k*C +: C]);
    end
    in_color = in_tdata[6*C +: COLOR_BITS];
  end

  // setup and scan sequencer
  tefr_seq #(.COORD_BITS(COORD_BITS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_req_type(in_tuser),
    .in_vtx     (in_vtx),
    .in_color   (in_color),
    .dn_valid   (dn_valid),
    .dn_ready   (dn_ready),
    .dn_ctl     (dn_ctl),
    .dn_px      (dn_px),
    .dn_py      (dn_py),
    .dn_dx      (dn_dx),
    .dn_dy      (dn_dy),
    .dn_ex      (dn_ex),
    .dn_ey      (dn_ey),
    .dn_bias    (dn_bias),
    .dn_color   (dn_color)
  );

  // edge evaluation and result register
  tefr_edge_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (dn_valid),
    .up_ready   (dn_ready),
    .up_ctl     (dn_ctl),
    .up_px      (dn_px),
    .up_py      (dn_py),
    .up_dx      (dn_dx),
    .up_dy      (dn_dy),
    .up_ex      (dn_ex),
    .up_ey      (dn_ey),
    .up_bias    (dn_bias),
    .up_color   (dn_color),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_px     (res_px),
    .out_py     (res_py),
    .out_color  (res_color),
    .out_last   (out_tlast)
  );

  // pack the result payload
  assign out_tdata = OUT_DW'({res_color, res_py, res_px});
  assign out_tuser = res_status;

endmodule

### sim/triangle_edge_function_rasterizer_tb.sv
// self-checking testbench for the half-space triangle rasterizer with a scan predictor
`timescale 1ns / 1ps

module triangle_edge_function_rasterizer_tb;
  import tefr_pkg::*;

  localparam int CB          = COORD_BITS_DEF;
  localparam int IN_W        = ((6*CB+COLOR_BITS+7)/8)*8;
  localparam int OUT_W       = ((2*CB+COLOR_BITS+7)/8)*8;
  localparam int CMIN        = -(1 << (CB-1));
  localparam int CMAX        = (1 << (CB-1)) - 1;
  localparam int SEG_ITEMS   = 100;
  localparam int N_SEGS      = 9;
  localparam int CYCLE_LIMIT = 400000;

  // one request as driven: x1,y1,x2,y2,x3,y3 in v[0..5]
  typedef struct packed {
    logic                  kind;
    logic [COLOR_BITS-1:0] color;
    logic [5:0][CB-1:0]    v;
  } tri_req_t;

  typedef struct packed {
    status_t               status;
    logic [CB-1:0]         px;
    logic [CB-1:0]         py;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pix_result_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CANVAS_WIDTH;
  logic [CANVAS_BITS-1:0]    cfg_wdata = '0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_W-1:0]           in_tdata  = '0;
  logic                      in_tuser  = REQ_LOAD;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_W-1:0]          out_tdata;
  logic [STATUS_BITS-1:0]    out_tuser;
  logic                      out_tlast;

  // predictor copy of configuration and triangle state
  int          canvas_w = 640;
  int          canvas_h = 480;
  logic        bias_mode = 1'b0;
  int          vx[3];
  int          vy[3];
  logic [31:0] fill_color = '0;
  int          edge_bias[3];
  int          box_y_min, box_x_max, box_y_max;
  int          scan_x, scan_y;
  logic        tri_active = 1'b0;

  tri_req_t    pending_reqs[$];
  pix_result_t expected_pixels[$];
  tri_req_t    drv_req;
  pix_result_t exp_pix;

  int send_idle_pct  = 23;
  int recv_stall_pct = 58;
  int n_errors = 0;
  int n_loads = 0;
  int n_steps = 0;
  int status_seen[8];
  int cycle_count = 0;

  // per-segment canvas settings, -1 picks a random value
  int seg_w[N_SEGS]    = '{640, 4096, 1, 4096, 1, -1, 0, 8191, -1};
  int seg_h[N_SEGS]    = '{480, 4096, 1, 1, 4096, -1, 4096, 8191, -1};
  int seg_bias[N_SEGS] = '{1, 0, 1, 1, 0, 1, 1, 1, -1};

  triangle_edge_function_rasterizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int min3(int a, int b, int c);
    int m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic int max3(int a, int b, int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic int clamp_coord(int c);
    if (c < CMIN) return CMIN;
    if (c > CMAX) return CMAX;
    return c;
  endfunction

  // computes the result of one request and advances the triangle state
  function automatic pix_result_t rasterize_item(tri_req_t it);
    pix_result_t r;
    int          xmin, xmax, ymin, ymax, ev, b;
    logic        covered;
    r = '0;
    if (it.kind == REQ_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        vx[i] = int'($signed(it.v[2*i]));
        vy[i] = int'($signed(it.v[2*i+1]));
      end
      fill_color = it.color;
      xmin = min3(vx[0], vx[1], vx[2]);
      xmax = max3(vx[0], vx[1], vx[2]);
      ymin = min3(vy[0], vy[1], vy[2]);
      ymax = max3(vy[0], vy[1], vy[2]);
      if (xmax < 0 || xmin >= canvas_w || ymax < 0 || ymin >= canvas_h ||
          xmin == xmax || ymin == ymax) begin
        tri_active = 1'b0;
        r.status = ST_REJECT;
        r.last = 1'b1;
      end else begin
        // top-left rule: in bias mode, edges that are neither top nor left get a bias of one
        for (int i = 0; i < 3; i++) begin
          b = (i + 1) % 3;
          edge_bias[i] = (bias_mode &&
                          !((vy[i] == vy[b] && vx[i] < vx[b]) || vy[i] < vy[b])) ? 1 : 0;
        end
        box_y_min = ymin;
        box_x_max = xmax;
        box_y_max = ymax;
        scan_x = xmin;
        scan_y = ymin;
        tri_active = 1'b1;
        r.status = ST_ACCEPT;
      end
    end else if (!tri_active) begin
      r.status = ST_IDLE;
    end else begin
      covered = 1'b1;
      for (int i = 0; i < 3; i++) begin
        b = (i + 1) % 3;
        ev = (vx[b] - vx[i]) * (scan_y - vy[i]) - (vy[b] - vy[i]) * (scan_x - vx[i]);
        if (ev + edge_bias[i] > 0) covered = 1'b0;
      end
      r.px = CB'(scan_x);
      r.py = CB'(scan_y);
      if (covered && scan_x >= 0 && scan_x < canvas_w && scan_y >= 0 && scan_y < canvas_h) begin
        r.status = ST_WRITE;
        r.color = fill_color;
      end else begin
        r.status = ST_SKIP;
      end
      // y runs inside x, max exclusive
      if (scan_x == box_x_max - 1 && scan_y == box_y_max - 1) begin
        r.last = 1'b1;
        tri_active = 1'b0;
      end else begin
        scan_y++;
        if (scan_y >= box_y_max) begin
          scan_y = box_y_min;
          scan_x++;
        end
      end
    end
    return r;
  endfunction

  task automatic push_load(input int x1, y1, x2, y2, x3, y3, input logic [31:0] color);
    tri_req_t it;
    it.kind = REQ_LOAD;
    it.color = color;
    it.v[0] = CB'(x1);
    it.v[1] = CB'(y1);
    it.v[2] = CB'(x2);
    it.v[3] = CB'(y2);
    it.v[4] = CB'(x3);
    it.v[5] = CB'(y3);
    pending_reqs.push_back(it);
  endtask

  // steps carry random payload that the block must ignore
  task automatic push_steps(input int n);
    tri_req_t it;
    for (int i = 0; i < n; i++) begin
      it.kind = REQ_STEP;
      it.color = $urandom;
      for (int j = 0; j < 6; j++) it.v[j] = CB'($urandom);
      pending_reqs.push_back(it);
    end
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(2*CMAX+1)) + CMIN;
  endfunction

  // mostly small triangles near the canvas, usually followed by a full scan, plus noise
  task automatic fill_random(input int n_items);
    int goal, sel, cx, cy, d, area, nsteps;
    int xs[3];
    int ys[3];
    goal = pending_reqs.size() + n_items;
    while (pending_reqs.size() < goal) begin
      sel = $urandom_range(99);
      cx = int'($urandom_range(canvas_w + 7)) - 4;
      cy = int'($urandom_range(canvas_h + 7)) - 4;
      if (sel < 70) begin
        for (int k = 0; k < 3; k++) begin
          xs[k] = clamp_coord(cx + int'($urandom_range(8)) - 4);
          ys[k] = clamp_coord(cy + int'($urandom_range(8)) - 4);
        end
        push_load(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], $urandom);
        area = (max3(xs[0], xs[1], xs[2]) - min3(xs[0], xs[1], xs[2])) *
               (max3(ys[0], ys[1], ys[2]) - min3(ys[0], ys[1], ys[2]));
        nsteps = area;
        sel = $urandom_range(99);
        if (sel < 15) nsteps = $urandom_range(area);
        else if (sel < 30) nsteps = area + $urandom_range(1, 3);
        push_steps(nsteps);
      end else if (sel < 85) begin
        push_load(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), $urandom);
        push_steps($urandom_range(1, 3));
      end else if (sel < 95) begin
        push_steps($urandom_range(1, 3));
      end else if (sel < 98) begin
        // zero-width or zero-height box
        d = $urandom_range(1, 4);
        cx = clamp_coord(cx);
        cy = clamp_coord(cy);
        if ($urandom_range(1))
          push_load(cx, cy, cx, clamp_coord(cy + d), cx, clamp_coord(cy - d), $urandom);
        else
          push_load(cx, cy, clamp_coord(cx + d), cy, clamp_coord(cx - d), cy, $urandom);
        push_steps(1);
      end else begin
        // collinear vertices: only pixels on the line can pass
        cx = clamp_coord(cx);
        cy = clamp_coord(cy);
        push_load(cx, cy, clamp_coord(cx + 2), clamp_coord(cy + 2),
                  clamp_coord(cx + 4), clamp_coord(cy + 4), $urandom);
        push_steps(16);
      end
    end
  endtask

  // configuration write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CANVAS_BITS'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CANVAS_WIDTH:  canvas_w = value & ((1 << CANVAS_BITS) - 1);
      REG_CANVAS_HEIGHT: canvas_h = value & ((1 << CANVAS_BITS) - 1);
      REG_FILL_BIAS:     bias_mode = value[0];
      default: ;
    endcase
  endtask

  task automatic drain_pipeline();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_pixels.size() != 0);
  endtask

  // request driver: predicts each accepted transfer, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(rasterize_item(drv_req));
        if (drv_req.kind == REQ_LOAD) n_loads++;
        else n_steps++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= drv_req.kind;
          in_tdata <= {{(IN_W-6*CB-COLOR_BITS){1'b0}}, drv_req.color, drv_req.v};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result backpressure
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("result transfer with nothing expected: status %0d", out_tuser);
        n_errors++;
      end else begin
        exp_pix = expected_pixels.pop_front();
        status_seen[exp_pix.status]++;
        if (out_tuser !== exp_pix.status) begin
          $error("status: expected %0d, got %0d", exp_pix.status, out_tuser);
          n_errors++;
        end
        if (out_tdata[CB-1:0] !== exp_pix.px) begin
          $error("pixel_x: expected %0d, got %0d", $signed(exp_pix.px),
                 $signed(out_tdata[CB-1:0]));
          n_errors++;
        end
        if (out_tdata[2*CB-1:CB] !== exp_pix.py) begin
          $error("pixel_y: expected %0d, got %0d", $signed(exp_pix.py),
                 $signed(out_tdata[2*CB-1:CB]));
          n_errors++;
        end
        if (out_tdata[2*CB+COLOR_BITS-1:2*CB] !== exp_pix.color) begin
          $error("pixel_color: expected %h, got %h", exp_pix.color,
                 out_tdata[2*CB+COLOR_BITS-1:2*CB]);
          n_errors++;
        end
        if (out_tlast !== exp_pix.last) begin
          $error("last_pixel: expected %0b, got %0b", exp_pix.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle step, full scan of a small triangle, rejects, extremes, replace
    push_steps(1);
    push_load(0, 0, 3, 0, 0, 3, 32'hFFFF_FFFF);
    push_steps(10);
    push_load(5, 1, 5, 9, 5, 4, 32'h1234_5678);
    push_load(-9, -1, -3, -5, -1, -2, 32'h0);
    push_load(640, 10, 700, 20, 650, 30, 32'hA5A5_A5A5);
    push_load(10, 480, 20, 500, 30, 490, 32'h5A5A_5A5A);
    push_load(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, 32'h0);
    push_steps(2);
    push_load(639, 479, 641, 479, 639, 481, 32'h00C0_FFEE);
    push_steps(4);
    drain_pipeline();

    // random segments under several canvas settings and idle patterns
    for (int s = 0; s < N_SEGS; s++) begin
      if (s == 3) begin
        send_idle_pct = 58;
        recv_stall_pct = 23;
      end else if (s == 6) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_reg(REG_CANVAS_WIDTH,  (seg_w[s] < 0) ? $urandom_range(1, 4096) : seg_w[s]);
      write_reg(REG_CANVAS_HEIGHT, (seg_h[s] < 0) ? $urandom_range(1, 4096) : seg_h[s]);
      write_reg(REG_FILL_BIAS,     (seg_bias[s] < 0) ? $urandom_range(1) : seg_bias[s]);
      @(negedge clk);
      fill_random(SEG_ITEMS);
      drain_pipeline();
    end

    repeat (20) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d results never arrived", expected_pixels.size());
      n_errors++;
    end

    $display("sent %0d loads and %0d steps across %0d canvas and fill-rule settings",
             n_loads, n_steps, N_SEGS + 1);
    $display("results: %0d accepted, %0d rejected, %0d written, %0d not written, %0d idle",
             status_seen[ST_ACCEPT], status_seen[ST_REJECT], status_seen[ST_WRITE],
             status_seen[ST_SKIP], status_seen[ST_IDLE]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
sv/tefr_pkg.sv
sv/tefr_seq.sv
sv/tefr_edge_eval.sv
sv/triangle_edge_function_rasterizer.sv
sim/triangle_edge_function_rasterizer_tb.sv
